@@ design/rdss_pkg.sv @@
`timescale 1ns / 1ps

package rdss_pkg;

	// Width of the number that is split into digits (4..32).
	localparam int VALUE_BITS = 16;
	localparam int CNT_W      = $clog2(VALUE_BITS);

	localparam int IN_W       = 16;   // value field
	localparam int SEG_W      = 8;
	localparam int POS_W      = 4;
	localparam int RADIX_W    = 4;
	localparam int OUT_DATA_W = 16;   // segments + position, padded to bytes

	localparam int MAX_DIGITS = 16;

	localparam logic [RADIX_W-1:0] RADIX_MIN   = 4'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX   = 4'd10;
	localparam logic [RADIX_W-1:0] RADIX_RESET = 4'd10;

	// Active-low segment patterns for digits 0..9.
	function automatic logic [SEG_W-1:0] seg_of(input logic [RADIX_W-1:0] digit);
		logic [SEG_W-1:0] seg;
		unique case (digit)
			4'd0:    seg = 8'h82;
			4'd1:    seg = 8'hBB;
			4'd2:    seg = 8'h85;
			4'd3:    seg = 8'h91;
			4'd4:    seg = 8'hB8;
			4'd5:    seg = 8'hD0;
			4'd6:    seg = 8'hC0;
			4'd7:    seg = 8'h9B;
			4'd8:    seg = 8'h80;
			4'd9:    seg = 8'h90;
			default: seg = 8'h82;   // digit never exceeds radix-1
		endcase
		return seg;
	endfunction

endpackage

@@ design/radix_digit_seven_segment_scan.sv @@
`timescale 1ns / 1ps

// Splits each incoming value into digits of the programmed radix (2..10),
// least significant digit first, and sends one output transfer per digit:
// the active-low seven-segment byte, the display position (0 = least
// significant) and tlast on the final digit. Zero yields a single '0' digit;
// at most 16 digits are sent per value. Each digit comes out of a bit-serial
// restoring divider that shifts the value through a VALUE_BITS-long register,
// one quotient bit per cycle. A finished digit waits until the output
// register is free, so a stalling output side slows the whole value. A
// new value is taken once the last digit of the previous one sits in the
// output register. Radix writes clamp to 2..10, are always accepted, and
// must only happen while no value is in flight.
module radix_digit_seven_segment_scan (
	input  logic                              clk,
	input  logic                              arst_n,
	// config: radix [3:0]
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [rdss_pkg::RADIX_W-1:0]      cfg_data,
	// s_tdata: value [15:0]
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [rdss_pkg::IN_W-1:0]         s_tdata,
	// m_tdata: segments [7:0], position [11:8], zero [15:12]
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [rdss_pkg::OUT_DATA_W-1:0]   m_tdata,
	output logic                              m_tlast
);
	import rdss_pkg::*;

	typedef enum logic [1:0] {
		IDLE,
		DIV,
		EMIT
	} state_t;

	state_t                  state_q;
	logic [RADIX_W-1:0]      radix_q;
	logic [VALUE_BITS-1:0]   num_q;     // dividend in, quotient shifts in from the bottom
	logic [RADIX_W-1:0]      rem_q;     // partial remainder, always < radix
	logic [CNT_W-1:0]        cnt_q;     // quotient bits still to produce, minus one
	logic                    nz_q;      // some quotient bit was 1
	logic [POS_W-1:0]        pos_q;
	logic                    m_tvalid_q;
	logic [OUT_DATA_W-1:0]   m_tdata_q;
	logic                    m_tlast_q;

	logic [RADIX_W:0]        rem_ext;
	logic                    q_bit;
	logic [RADIX_W:0]        rem_sub;
	logic [RADIX_W-1:0]      cfg_clamped;
	logic                    out_free;
	logic                    digit_last;

	// one restoring-division step per cycle
	assign rem_ext = {rem_q, num_q[VALUE_BITS-1]};
	assign q_bit   = (rem_ext >= {1'b0, radix_q});
	assign rem_sub = q_bit ? (rem_ext - {1'b0, radix_q}) : rem_ext;

	always_comb begin
		priority if (cfg_data < RADIX_MIN) begin
			cfg_clamped = RADIX_MIN;
		end else if (cfg_data > RADIX_MAX) begin
			cfg_clamped = RADIX_MAX;
		end else begin
			cfg_clamped = cfg_data;
		end
	end

	assign out_free   = !m_tvalid_q || m_tready;
	// quotient zero: nothing left to show; or the display row is full
	assign digit_last = !nz_q || (pos_q == POS_W'(MAX_DIGITS - 1));

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == IDLE);
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;
	assign m_tlast   = m_tlast_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= IDLE;
			radix_q    <= RADIX_RESET;
			m_tvalid_q <= 1'b0;
			num_q      <= '0;
			rem_q      <= '0;
			cnt_q      <= '0;
			nz_q       <= 1'b0;
			pos_q      <= '0;
			m_tdata_q  <= '0;
			m_tlast_q  <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				radix_q <= cfg_clamped;
			end

			// in EMIT a drained output register is reloaded below
			if (m_tvalid_q && m_tready && (state_q != EMIT)) begin
				m_tvalid_q <= 1'b0;
			end

			unique case (state_q)
				IDLE: begin
					if (s_tvalid) begin
						num_q   <= VALUE_BITS'(s_tdata);
						rem_q   <= '0;
						cnt_q   <= CNT_W'(VALUE_BITS - 1);
						nz_q    <= 1'b0;
						pos_q   <= '0;
						state_q <= DIV;
					end
				end
				DIV: begin
					num_q <= {num_q[VALUE_BITS-2:0], q_bit};
					rem_q <= rem_sub[RADIX_W-1:0];
					nz_q  <= nz_q | q_bit;
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						state_q <= EMIT;
					end
				end
				EMIT: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= OUT_DATA_W'({pos_q, seg_of(rem_q)});
						m_tlast_q  <= digit_last;
						if (digit_last) begin
							state_q <= IDLE;
						end else begin
							// quotient in num_q becomes the next dividend
							rem_q   <= '0;
							cnt_q   <= CNT_W'(VALUE_BITS - 1);
							nz_q    <= 1'b0;
							pos_q   <= pos_q + 1'b1;
							state_q <= DIV;
						end
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	// radix register never leaves the supported range
	a_radix_range: assert property (@(posedge clk) disable iff (!arst_n)
		(radix_q >= RADIX_MIN) && (radix_q <= RADIX_MAX))
		else $error("radix register out of range");

	// partial remainder stays below the divisor while dividing
	a_rem_below_radix: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == DIV) |-> (rem_q < radix_q))
		else $error("partial remainder not below radix");

	// a taken value blocks further input on the next cycle
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input accepted while a value is in progress");

	// a pending non-last digit means the block is still busy
	a_busy_with_digits: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tlast && (state_q != IDLE)) |-> !s_tready)
		else $error("ready while digits remain");

endmodule

@@ dv/tb_radix_digit_seven_segment_scan.sv @@
`timescale 1ns / 1ps

module tb_radix_digit_seven_segment_scan;
	import rdss_pkg::*;

	localparam int CLK_HALF      = 4;
	localparam int RESET_CYCLES  = 6;
	localparam int SETTLE_CYCLES = 24;
	localparam int CYCLE_LIMIT   = 1000000;
	localparam int RANDOM_PHASES = 7;
	localparam int PHASE_ITEMS   = 40;

	// active-low patterns for digits 0..9
	localparam logic [SEG_W-1:0] SEG_LUT [10] = '{
		8'h82, 8'hBB, 8'h85, 8'h91, 8'hB8, 8'hD0, 8'hC0, 8'h9B, 8'h80, 8'h90
	};

	typedef struct packed {
		logic [SEG_W-1:0] seg;
		logic [POS_W-1:0] pos;
		logic             last;
	} digit_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [RADIX_W-1:0]    cfg_data;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_W-1:0]       s_tdata;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  m_tlast;

	digit_t             pending_digits[$];
	logic [RADIX_W-1:0] shadow_radix;
	bit                 full_rate;
	int                 failures;
	int                 cycle_count;
	int                 stall_left;

	radix_digit_seven_segment_scan dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always #CLK_HALF clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] w);
		if (w < RADIX_MIN)
			return RADIX_MIN;
		if (w > RADIX_MAX)
			return RADIX_MAX;
		return w;
	endfunction

	function automatic logic [IN_W-1:0] random_value();
		int r;
		r = $urandom_range(0, 9);
		case (r)
			0:       return ($urandom_range(0, 1) != 0) ? '1 : '0;
			1, 2:    return IN_W'($urandom_range(0, 15));
			3:       return IN_W'($urandom_range(0, 999));
			default: return IN_W'($urandom);
		endcase
	endfunction

	// expected digit transfers for one value under the current radix
	function automatic void split_into_digits(input logic [IN_W-1:0] v);
		int unsigned num;
		int unsigned base;
		int          d;
		int          cnt;
		digit_t      e;
		num  = v;
		base = shadow_radix;
		cnt  = 0;
		do begin
			d = num % base;
			num = num / base;
			e.seg  = SEG_LUT[d];
			e.pos  = POS_W'(cnt);
			e.last = (num == 0) || (cnt == MAX_DIGITS - 1);
			pending_digits.push_back(e);
			cnt++;
		end while (num != 0 && cnt < MAX_DIGITS);
	endfunction

	// output side stalls; ready is raised again between any two stalls
	always @(negedge clk) begin
		if (arst_n) begin
			if (stall_left > 0 && !full_rate) begin
				m_tready <= 1'b0;
				stall_left--;
			end else begin
				m_tready <= 1'b1;
				stall_left = full_rate ? 0 : pick_gap();
			end
		end
	end

	// digit checker
	always @(posedge clk) begin
		digit_t e;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_digits.size() == 0) begin
				$error("unexpected digit transfer: m_tdata=%h m_tlast=%b", m_tdata, m_tlast);
				failures++;
			end else begin
				e = pending_digits.pop_front();
				if (m_tdata[SEG_W-1:0] !== e.seg) begin
					$error("segments: expected %h, actual %h", e.seg, m_tdata[SEG_W-1:0]);
					failures++;
				end
				if (m_tdata[SEG_W +: POS_W] !== e.pos) begin
					$error("position: expected %0d, actual %0d", e.pos, m_tdata[SEG_W +: POS_W]);
					failures++;
				end
				if (m_tlast !== e.last) begin
					$error("last_digit: expected %b, actual %b", e.last, m_tlast);
					failures++;
				end
				if (m_tdata[OUT_DATA_W-1:SEG_W+POS_W] !== '0) begin
					$error("padding: expected 0, actual %h", m_tdata[OUT_DATA_W-1:SEG_W+POS_W]);
					failures++;
				end
			end
		end
	end

	task automatic send_value(input logic [IN_W-1:0] v);
		int gap;
		gap = full_rate ? 0 : pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= v;
		do @(posedge clk); while (!s_tready);
		split_into_digits(v);
	endtask

	// stop sending and wait until every digit is out and the block is idle
	task automatic settle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_digits.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_radix(input logic [RADIX_W-1:0] w);
		settle();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= w;
		do @(posedge clk); while (!cfg_ready);
		shadow_radix = clamp_radix(w);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// decimal split straight out of reset, no register write yet
	task automatic test_reset_radix();
		send_value('0);
		send_value('1);
		send_value(16'd1);
		send_value(16'd9);
		send_value(16'd10);
		send_value(16'h8000);
	endtask

	// every possible write value, out-of-range ones must clamp
	task automatic test_radix_clamp();
		for (int w = 0; w < 16; w++) begin
			write_radix(RADIX_W'(w));
			case (w % 4)
				0:       send_value('1);
				1:       send_value('0);
				2:       send_value(16'h8000);
				default: send_value(random_value());
			endcase
		end
	endtask

	task automatic test_random_values();
		logic [RADIX_W-1:0] w;
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			case (p)
				0:       w = RADIX_MIN;
				1:       w = RADIX_MAX;
				default: w = RADIX_W'($urandom_range(0, 15));
			endcase
			write_radix(w);
			full_rate = (p == 3);
			for (int i = 0; i < PHASE_ITEMS; i++)
				send_value(random_value());
			full_rate = 1'b0;
		end
	endtask

	initial begin
		clk          = 1'b0;
		arst_n       = 1'b0;
		cfg_valid    = 1'b0;
		cfg_data     = '0;
		s_tvalid     = 1'b0;
		s_tdata      = '0;
		m_tready     = 1'b0;
		shadow_radix = RADIX_RESET;
		full_rate    = 1'b0;
		failures     = 0;
		cycle_count  = 0;
		stall_left   = 0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_radix();
		test_radix_clamp();
		test_random_values();
		settle();

		if (failures == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
